@@ hdl/input_event_latency_monitor_unit_assert.svh @@
// Assertion macros for the event latency monitor.
// Used by the top level; relies on clk and arst_n being in scope.
`ifndef INPUT_EVENT_LATENCY_MONITOR_UNIT_ASSERT_SVH
`define INPUT_EVENT_LATENCY_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IELM_ASSERT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define IELM_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ hdl/ielm_pkg.sv @@
// Package for the event latency monitor: item types, codes, limits, FSM states.
// No dependencies.
package ielm_pkg;

	localparam int CNT_W  = 32;
	localparam int SUM_W  = 48;
	localparam int LAT_W  = 31;
	localparam int RATE_W = 10;
	localparam int STEP_W = 6;

	localparam logic [1:0] FUNC_RECORD = 2'd0;
	localparam logic [1:0] FUNC_QUERY  = 2'd1;
	localparam logic [1:0] FUNC_ADAPT  = 2'd2;

	localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
	localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
	localparam logic [LAT_W-1:0]  LAT_MAX   = '1;
	localparam logic [31:0]       MIN_UNSET = '1;

	localparam logic [RATE_W-1:0] RATE_NUM  = 10'd1000;
	localparam logic [RATE_W-1:0] RATE_HI   = 10'd60;
	localparam logic [RATE_W-1:0] RATE_LO   = 10'd30;
	localparam logic [STEP_W-1:0] RATE_STEPS = STEP_W'(RATE_W);
	localparam logic [STEP_W-1:0] AVG_STEPS  = STEP_W'(SUM_W);

	localparam logic [3:0] RESP_FAST  = 4'd2;
	localparam logic [3:0] RESP_MID   = 4'd5;
	localparam logic [3:0] RESP_SLOW  = 4'd10;
	localparam logic [3:0] PRIO_TOP   = 4'd10;
	localparam logic [3:0] PRIO_OTHER = 4'd5;
	localparam logic [3:0] PRIO_NONE  = 4'd0;

	typedef struct packed {
		logic [1:0]         func;
		logic [31:0]        timestamp_ms;
		logic [3:0]         dev_kind;
		logic signed [31:0] lat_sample;
	} in_item_t;

	typedef struct packed {
		logic [RATE_W-1:0] event_rate;
		logic [CNT_W-1:0]  total_events;
		logic [LAT_W-1:0]  average_latency;
		logic [LAT_W-1:0]  max_latency;
		logic [LAT_W-1:0]  min_latency;
		logic [CNT_W-1:0]  type_count;
		logic [3:0]        type_priority;
		logic [3:0]        response_setting;
		logic              status;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
		logic [SUM_W-1:0]  dividend;
		logic [CNT_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_RATE_GO,
		S_RATE_WAIT,
		S_AVG_GO,
		S_AVG_WAIT,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_OUT
	} state_t;

endpackage

@@ hdl/ielm_stream_if.sv @@
// Valid/ready channel carrying one item of a given payload type.
// No dependencies.
interface ielm_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/ielm_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on ielm_pkg.
module ielm_divider import ielm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [CNT_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             ge;
	logic [CNT_W-1:0] rem_nx;

	assign trial  = {rem_q, quo_q[SUM_W-1]};
	assign diff   = trial - {1'b0, dvs_q};
	assign ge     = trial >= {1'b0, dvs_q};
	assign rem_nx = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ hdl/ielm_count_ram.sv @@
// Per-type event counter memory with registered read and per-entry valid bits.
// Depends on ielm_pkg.
module ielm_count_ram import ielm_pkg::*; #(
	parameter int NUM_TYPES = 10,
	localparam int IDX_W = $clog2(NUM_TYPES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [CNT_W-1:0] rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [CNT_W-1:0] wr_data
);

	logic [CNT_W-1:0]     mem [NUM_TYPES];
	logic [NUM_TYPES-1:0] valid_q;
	logic [CNT_W-1:0]     rd_data_q;

	// an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/input_event_latency_monitor_unit.sv @@
// Top level of the event rate and latency monitor: control FSM and statistics.
// Depends on ielm_pkg, ielm_stream_if, ielm_divider, ielm_count_ram and the assert header.
//
//  channel | dir | payload    | handshake
//  --------+-----+------------+----------------------------
//  req     | in  | in_item_t  | valid/ready, taken when both high
//  rsp     | out | out_item_t | valid/ready, one item per req item
//
// One item is worked at a time; req.ready is high only while the FSM is idle.
// Record: the 48-step average division runs in the shared divider, preceded by the
// 10-step rate division when the rate is updated.
// Query: goes straight to the output state. Adapt: one counter memory read per type.
// The result register lets the next item be accepted while rsp is stalled; a
// finished item waits in the output state until the register frees up.
// Reset (arst_n) clears all statistics at once, the per-type counts through valid bits; no sweep.
`include "input_event_latency_monitor_unit_assert.svh"
module input_event_latency_monitor_unit import ielm_pkg::*; #(
	parameter int NUM_TYPES = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	ielm_stream_if.sink   req,
	ielm_stream_if.source rsp
);

	localparam int IDX_W = $clog2(NUM_TYPES);

	state_t state_q, state_nx;

	// captured item
	logic [1:0]       func_q;
	logic [31:0]      ts_q;
	logic [31:0]      lat_q;
	logic [IDX_W-1:0] dev_idx_q;
	logic             dev_ok_q;

	// statistics
	logic [CNT_W-1:0]  total_q;
	logic [SUM_W-1:0]  sum_q;
	logic [LAT_W-1:0]  max_q;
	logic [31:0]       min_q;
	logic [31:0]       prev_q;
	logic [RATE_W-1:0] rate_q;
	logic [LAT_W-1:0]  avg_q;
	logic [3:0]        resp_set_q;
	logic              prio_valid_q;
	logic [IDX_W-1:0]  best_q;

	// work registers
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] gap_q;
	logic [IDX_W-1:0] scan_q;
	logic [IDX_W-1:0] cand_q;
	logic [CNT_W-1:0] best_cnt_q;

	// result register
	out_item_t out_q;
	logic      out_valid_q;

	// memory and divider hookup
	logic             ram_rd_en;
	logic [IDX_W-1:0] ram_rd_addr;
	logic [CNT_W-1:0] ram_rdata;
	logic             ram_wr_en;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	logic accept;
	logic dev_ok_in;
	logic out_load;
	logic rate_cond;
	logic lat_pos;
	logic [SUM_W:0] sum_nx;
	logic scan_last;
	logic scan_gt;
	logic [CNT_W-1:0] scan_best_cnt;
	logic [3:0] prio_out;
	logic div_wait;

	assign accept    = req.valid && req.ready;
	assign dev_ok_in = 6'(req.payload.dev_kind) < 6'(NUM_TYPES);
	assign rate_cond = (prev_q != '0) && (ts_q > prev_q);
	assign lat_pos   = !lat_q[31] && (lat_q != '0);
	assign sum_nx    = {1'b0, sum_q} + (SUM_W+1)'(lat_q[LAT_W-1:0]);
	assign scan_last = scan_q == IDX_W'(NUM_TYPES - 1);
	assign scan_gt   = ram_rdata > best_cnt_q;
	assign scan_best_cnt = scan_gt ? ram_rdata : best_cnt_q;
	assign div_wait  = (state_q == S_RATE_WAIT) || (state_q == S_AVG_WAIT);

	ielm_count_ram #(.NUM_TYPES(NUM_TYPES)) u_count_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rdata),
		.wr_en   (ram_wr_en),
		.wr_addr (dev_idx_q),
		.wr_data (ram_rdata + 1'b1)
	);

	ielm_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_nx = S_READ;
			end
			S_READ: begin
				priority if (func_q == FUNC_RECORD) begin
					state_nx = rate_cond ? S_RATE_GO : S_AVG_GO;
				end else if (func_q == FUNC_ADAPT) begin
					state_nx = S_SCAN_RD;
				end else begin
					state_nx = S_OUT;
				end
			end
			S_RATE_GO:   state_nx = S_RATE_WAIT;
			S_RATE_WAIT: begin
				if (div_rsp.done) state_nx = S_AVG_GO;
			end
			S_AVG_GO:    state_nx = S_AVG_WAIT;
			S_AVG_WAIT: begin
				if (div_rsp.done) state_nx = S_OUT;
			end
			S_SCAN_RD:   state_nx = S_SCAN_CMP;
			S_SCAN_CMP:  state_nx = scan_last ? S_OUT : S_SCAN_RD;
			S_OUT: begin
				if (out_load) state_nx = S_IDLE;
			end
			default:     state_nx = S_IDLE;
		endcase
	end

	// outputs of the FSM
	always_comb begin
		req.ready        = 1'b0;
		ram_rd_en        = 1'b0;
		ram_rd_addr      = scan_q;
		ram_wr_en        = 1'b0;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.steps    = AVG_STEPS;
		div_req.dividend = sum_q;
		div_req.divisor  = total_q;
		unique case (state_q)
			S_IDLE: begin
				req.ready   = 1'b1;
				ram_rd_en   = req.valid && dev_ok_in;
				ram_rd_addr = IDX_W'(req.payload.dev_kind);
			end
			S_READ: begin
				ram_wr_en = (func_q == FUNC_RECORD) && dev_ok_q && (ram_rdata != CNT_MAX);
			end
			S_RATE_GO: begin
				div_req.start    = 1'b1;
				div_req.steps    = RATE_STEPS;
				// left-align the numerator so only RATE_W steps are needed
				div_req.dividend = {RATE_NUM, (SUM_W-RATE_W)'(0)};
				div_req.divisor  = gap_q;
			end
			S_AVG_GO: begin
				div_req.start = 1'b1;
			end
			S_SCAN_RD: begin
				ram_rd_en = 1'b1;
			end
			S_OUT: begin
				out_load = !out_valid_q || rsp.ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// capture the item
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= req.payload.func;
			ts_q      <= req.payload.timestamp_ms;
			lat_q     <= req.payload.lat_sample;
			dev_idx_q <= IDX_W'(req.payload.dev_kind);
			dev_ok_q  <= dev_ok_in;
		end
	end

	// statistics update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= '0;
			sum_q        <= '0;
			max_q        <= '0;
			min_q        <= MIN_UNSET;
			prev_q       <= '0;
			rate_q       <= '0;
			avg_q        <= '0;
			resp_set_q   <= RESP_MID;
			prio_valid_q <= 1'b0;
			best_q       <= '0;
		end else begin
			if (state_q == S_READ && func_q == FUNC_RECORD) begin
				prev_q <= ts_q;
				if (total_q != CNT_MAX) total_q <= total_q + 1'b1;
				if (lat_pos) begin
					sum_q <= sum_nx[SUM_W] ? SUM_MAX : sum_nx[SUM_W-1:0];
					if (lat_q[LAT_W-1:0] > max_q) max_q <= lat_q[LAT_W-1:0];
					if (lat_q < min_q) min_q <= lat_q;
				end
			end
			if (state_q == S_READ && func_q == FUNC_ADAPT) begin
				priority if (rate_q > RATE_HI) begin
					resp_set_q <= RESP_FAST;
				end else if (rate_q > RATE_LO) begin
					resp_set_q <= RESP_MID;
				end else begin
					resp_set_q <= RESP_SLOW;
				end
			end
			if (state_q == S_RATE_WAIT && div_rsp.done) begin
				rate_q <= div_rsp.quotient[RATE_W-1:0];
			end
			if (state_q == S_AVG_WAIT && div_rsp.done) begin
				// clamp the average to the output range
				avg_q <= (|div_rsp.quotient[SUM_W-1:LAT_W]) ? LAT_MAX
					: div_rsp.quotient[LAT_W-1:0];
			end
			// first maximum wins; all-zero counts leave priorities alone
			if (state_q == S_SCAN_CMP && scan_last && scan_best_cnt != '0) begin
				prio_valid_q <= 1'b1;
				best_q       <= scan_gt ? scan_q : cand_q;
			end
		end
	end

	// work registers: addressed count, gap, scan
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			gap_q      <= ts_q - prev_q;
			scan_q     <= '0;
			cand_q     <= '0;
			best_cnt_q <= '0;
			priority if (!dev_ok_q) begin
				count_q <= '0;
			end else if (func_q == FUNC_RECORD && ram_rdata != CNT_MAX) begin
				count_q <= ram_rdata + 1'b1;
			end else begin
				count_q <= ram_rdata;
			end
		end
		if (state_q == S_SCAN_CMP) begin
			if (scan_gt) begin
				best_cnt_q <= ram_rdata;
				cand_q     <= scan_q;
			end
			if (!scan_last) scan_q <= scan_q + 1'b1;
		end
	end

	// result assembly
	always_comb begin
		prio_out = PRIO_NONE;
		if (dev_ok_q && prio_valid_q) begin
			prio_out = (dev_idx_q == best_q) ? PRIO_TOP : PRIO_OTHER;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.event_rate       <= rate_q;
			out_q.total_events     <= total_q;
			out_q.average_latency  <= avg_q;
			out_q.max_latency      <= max_q;
			out_q.min_latency      <= (min_q == MIN_UNSET) ? '0 : min_q[LAT_W-1:0];
			out_q.type_count       <= count_q;
			out_q.type_priority    <= prio_out;
			out_q.response_setting <= resp_set_q;
			out_q.status           <= !dev_ok_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	`IELM_ASSERT(a_div_done_wait, div_rsp.done, div_wait, "divider done outside a wait state")
	`IELM_ASSERT(a_wr_record, ram_wr_en, (func_q == FUNC_RECORD && dev_ok_q), "stray counter write")
	`IELM_ASSERT(a_min_le_max, (min_q != MIN_UNSET), (32'(max_q) >= min_q), "minimum above maximum")
	`IELM_ASSERT(a_sum_needs_total, (total_q == '0), (sum_q == '0), "latency sum without events")
	`IELM_ASSERT_NEXT(a_load_frees, out_load, (req.ready && rsp.valid), "load did not go idle")

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for input_event_latency_monitor_unit: directed table, then random items.
// Depends on ielm_pkg, ielm_stream_if and the monitor RTL; results are checked by a local model.
module tb_top;
	import ielm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_TYPES = 10;
	localparam int RANDOM_ITEMS = 750;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 80;
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	typedef struct {
		in_item_t  stim;
		bit        typed;
		out_item_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	ielm_stream_if #(.payload_t(in_item_t))  req_if ();
	ielm_stream_if #(.payload_t(out_item_t)) rsp_if ();

	input_event_latency_monitor_unit #(.NUM_TYPES(N_TYPES)) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	always #5 clk = ~clk;

	// Shadow copy of the monitor statistics, advanced once per accepted item.
	logic [31:0]       type_hits [N_TYPES];
	logic [3:0]        type_prio [N_TYPES];
	logic [31:0]       events_seen;
	logic [SUM_W-1:0]  lat_total;
	logic [LAT_W-1:0]  lat_peak;
	logic [31:0]       lat_floor;
	logic [31:0]       last_ms;
	logic [RATE_W-1:0] rate_now;
	logic [3:0]        resp_now;

	out_item_t   pending_stats[$];
	plan_row_t   plan[$];
	int          failures = 0;
	int          cycles = 0;
	bit          calm = 1'b0;
	logic [31:0] sim_ms = '0;

	// Hard stop in case the block hangs on a handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// Apply one item to the shadow statistics and return the result the block must report.
	function automatic out_item_t monitor_after(input in_item_t it);
		out_item_t        r;
		logic [31:0]      lat;
		logic [63:0]      acc;
		logic [SUM_W-1:0] mean;
		logic [31:0]      top_count;
		int               top_idx;
		int               dev;
		bit               dev_ok;
		lat = it.lat_sample;
		dev = it.dev_kind;
		dev_ok = dev < N_TYPES;
		if (it.func == FUNC_RECORD) begin
			// Rate moves only on a forward step from a nonzero previous time.
			if (last_ms != '0 && it.timestamp_ms > last_ms)
				rate_now = RATE_W'(32'(RATE_NUM) / (it.timestamp_ms - last_ms));
			last_ms = it.timestamp_ms;
			if (dev_ok && type_hits[dev] != CNT_MAX)
				type_hits[dev] = type_hits[dev] + 1;
			if (events_seen != CNT_MAX)
				events_seen = events_seen + 1;
			// Fold only strictly positive latencies.
			if (!lat[31] && lat != '0) begin
				acc = 64'(lat_total) + 64'(lat);
				lat_total = (acc > 64'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
				if (lat > {1'b0, lat_peak})
					lat_peak = lat[LAT_W-1:0];
				if (lat < lat_floor)
					lat_floor = lat;
			end
		end else if (it.func == FUNC_ADAPT) begin
			if (rate_now > RATE_HI)
				resp_now = RESP_FAST;
			else if (rate_now > RATE_LO)
				resp_now = RESP_MID;
			else
				resp_now = RESP_SLOW;
			// First type holding the largest count takes the top priority.
			top_count = '0;
			top_idx = 0;
			for (int i = 0; i < N_TYPES; i++) begin
				if (type_hits[i] > top_count) begin
					top_count = type_hits[i];
					top_idx = i;
				end
			end
			if (top_count != '0) begin
				for (int i = 0; i < N_TYPES; i++)
					type_prio[i] = (i == top_idx) ? PRIO_TOP : PRIO_OTHER;
			end
		end
		mean = '0;
		if (events_seen != '0) begin
			mean = lat_total / SUM_W'(events_seen);
			if (mean > SUM_W'(LAT_MAX))
				mean = SUM_W'(LAT_MAX);
		end
		r.event_rate       = rate_now;
		r.total_events     = events_seen;
		r.average_latency  = mean[LAT_W-1:0];
		r.max_latency      = lat_peak;
		r.min_latency      = (lat_floor == MIN_UNSET) ? '0 : lat_floor[LAT_W-1:0];
		r.type_count       = dev_ok ? type_hits[dev] : '0;
		r.type_priority    = dev_ok ? type_prio[dev] : PRIO_NONE;
		r.response_setting = resp_now;
		r.status           = !dev_ok;
		return r;
	endfunction

	function automatic plan_row_t mk_row(input logic [1:0] f, input logic [31:0] ts,
			input logic [3:0] dev, input logic [31:0] lat, input bit typed, input out_item_t want);
		plan_row_t row;
		row.stim.func         = f;
		row.stim.timestamp_ms = ts;
		row.stim.dev_kind     = dev;
		row.stim.lat_sample   = lat;
		row.typed = typed;
		row.want  = want;
		return row;
	endfunction

	// Idle length for either side; calm stretches run back to back.
	function automatic int pause_len();
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	task automatic compare_field(input string field, input logic [47:0] want,
			input logic [47:0] got);
		if (got !== want) begin
			failures++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// Offer one item, hold it until taken, then queue the expected statistics.
	task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
		int        idle;
		out_item_t pred;
		idle = pause_len();
		if (idle > 0) begin
			req_if.valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.payload <= it;
		do @(posedge clk); while (!req_if.ready);
		pred = monitor_after(it);
		pending_stats.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	// Hold the sender until every outstanding result has come back.
	task automatic drain_results();
		req_if.valid <= 1'b0;
		while (pending_stats.size() != 0)
			@(negedge clk);
	endtask

	// Result side: stall at random, then take and check one item.
	initial begin
		int        idle;
		out_item_t got;
		out_item_t want;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			idle = pause_len();
			if (idle > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (idle) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
			got = rsp_if.payload;
			if (pending_stats.size() == 0) begin
				failures++;
				$display("%0t ns: unexpected result, expected none, actual %p", $time, got);
			end else begin
				want = pending_stats.pop_front();
				compare_field("event_rate", want.event_rate, got.event_rate);
				compare_field("total_events", want.total_events, got.total_events);
				compare_field("average_latency", want.average_latency, got.average_latency);
				compare_field("max_latency", want.max_latency, got.max_latency);
				compare_field("min_latency", want.min_latency, got.min_latency);
				compare_field("type_count", want.type_count, got.type_count);
				compare_field("type_priority", want.type_priority, got.type_priority);
				compare_field("response_setting", want.response_setting,
					got.response_setting);
				compare_field("status", want.status, got.status);
			end
			@(negedge clk);
		end
	end

	// Request side: reset, directed table, random traffic, then drain and report.
	initial begin
		in_item_t it;
		int       pick;
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		arst_n = 1'b0;

		// Shadow state starts from the reset values.
		foreach (type_hits[i]) begin
			type_hits[i] = '0;
			type_prio[i] = PRIO_NONE;
		end
		events_seen = '0;
		lat_total   = '0;
		lat_peak    = '0;
		lat_floor   = MIN_UNSET;
		last_ms     = '0;
		rate_now    = '0;
		resp_now    = RESP_MID;

		// Directed rows. Typed results are the obvious ones right after reset.
		plan.push_back(mk_row(FUNC_QUERY, 32'd0, 4'd0, 32'd0, 1'b1,
			out_item_t'{10'd0, 32'd0, 31'd0, 31'd0, 31'd0, 32'd0, PRIO_NONE, RESP_MID, 1'b0}));
		// Invalid type on a query: flagged, count and priority forced to zero.
		plan.push_back(mk_row(FUNC_QUERY, 32'hFFFF_FFFF, 4'd15, 32'h8000_0000, 1'b1,
			out_item_t'{10'd0, 32'd0, 31'd0, 31'd0, 31'd0, 32'd0, PRIO_NONE, RESP_MID, 1'b1}));
		// Adapt with every count zero: setting drops to slow, priorities untouched.
		plan.push_back(mk_row(FUNC_ADAPT, 32'd0, 4'd3, 32'd0, 1'b1,
			out_item_t'{10'd0, 32'd0, 31'd0, 31'd0, 31'd0, 32'd0, PRIO_NONE, RESP_SLOW, 1'b0}));
		// Record at time zero with zero latency: counted, nothing folded.
		plan.push_back(mk_row(FUNC_RECORD, 32'd0, 4'd0, 32'd0, 1'b1,
			out_item_t'{10'd0, 32'd1, 31'd0, 31'd0, 31'd0, 32'd1, PRIO_NONE, RESP_SLOW, 1'b0}));
		// Previous time still zero, so no rate; negative latency ignored.
		plan.push_back(mk_row(FUNC_RECORD, 32'd1000, 4'd9, 32'hFFFF_FFFF, 1'b1,
			out_item_t'{10'd0, 32'd2, 31'd0, 31'd0, 31'd0, 32'd1, PRIO_NONE, RESP_SLOW, 1'b0}));
		// Gap of one gives the top rate; largest latency.
		plan.push_back(mk_row(FUNC_RECORD, 32'd1001, 4'd9, 32'h7FFF_FFFF, 1'b0, '0));
		// Zero gap, invalid type, smallest positive latency.
		plan.push_back(mk_row(FUNC_RECORD, 32'd1001, 4'd15, 32'd1, 1'b0, '0));
		// Time runs backwards; most negative latency.
		plan.push_back(mk_row(FUNC_RECORD, 32'd500, 4'd2, 32'h8000_0000, 1'b0, '0));
		plan.push_back(mk_row(FUNC_RECORD, 32'd520, 4'd2, 32'd100, 1'b0, '0));
		// Tie between types 2 and 9: the lower index wins.
		plan.push_back(mk_row(FUNC_ADAPT, 32'd0, 4'd2, 32'd0, 1'b0, '0));
		plan.push_back(mk_row(FUNC_QUERY, 32'd0, 4'd9, 32'd0, 1'b0, '0));
		plan.push_back(mk_row(FUNC_QUERY, 32'd0, 4'd10, 32'd0, 1'b0, '0));
		// Largest timestamp, then wrap to zero, then restart from zero.
		plan.push_back(mk_row(FUNC_RECORD, 32'hFFFF_FFFF, 4'd5, 32'd5, 1'b0, '0));
		plan.push_back(mk_row(FUNC_RECORD, 32'd0, 4'd12, 32'd7, 1'b0, '0));
		plan.push_back(mk_row(FUNC_RECORD, 32'd40, 4'd1, 32'd3, 1'b0, '0));
		// Fast rate, then the rate thresholds from both sides.
		plan.push_back(mk_row(FUNC_RECORD, 32'd47, 4'd1, 32'd9, 1'b0, '0));
		plan.push_back(mk_row(FUNC_ADAPT, 32'd0, 4'd1, 32'd0, 1'b0, '0));
		plan.push_back(mk_row(FUNC_RECORD, 32'd80, 4'd0, 32'd2000, 1'b0, '0));
		plan.push_back(mk_row(FUNC_ADAPT, 32'd0, 4'd0, 32'd0, 1'b0, '0));
		plan.push_back(mk_row(FUNC_RECORD, 32'd112, 4'd4, 32'd11, 1'b0, '0));
		plan.push_back(mk_row(FUNC_ADAPT, 32'd0, 4'd4, 32'd0, 1'b0, '0));
		// Unused function code behaves as a query.
		plan.push_back(mk_row(FUNC_SPARE, 32'd123, 4'd2, 32'd44, 1'b0, '0));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i])
			push_item(plan[i].stim, plan[i].typed, plan[i].want);
		drain_results();
		sim_ms = 32'd200;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Switch between bursty idling and calm stretches now and then.
			if (n % 60 == 0)
				calm = ($urandom_range(0, 2) == 0);
			if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3)
				drain_results();

			pick = $urandom_range(0, 99);
			if (pick < 64)
				it.func = FUNC_RECORD;
			else if (pick < 80)
				it.func = FUNC_QUERY;
			else if (pick < 95)
				it.func = FUNC_ADAPT;
			else
				it.func = FUNC_SPARE;
			if ($urandom_range(0, 9) == 0)
				it.dev_kind = 4'($urandom_range(N_TYPES, 15));
			else
				it.dev_kind = 4'($urandom_range(0, N_TYPES - 1));
			// Unused fields carry noise; the block must ignore them.
			it.timestamp_ms = $urandom;
			it.lat_sample   = $urandom;

			if (it.func == FUNC_RECORD) begin
				// Mostly steady forward time so the rate sweeps through its range.
				pick = $urandom_range(0, 99);
				if (pick < 80)
					sim_ms = sim_ms + $urandom_range(0, 40);
				else if (pick < 88)
					sim_ms = sim_ms + $urandom_range(41, 2000);
				else if (pick < 94)
					sim_ms = $urandom;
				else if (pick < 97)
					sim_ms = '0;
				else
					sim_ms = sim_ms - $urandom_range(1, 50);
				it.timestamp_ms = sim_ms;

				pick = $urandom_range(0, 99);
				if (pick < 70)
					it.lat_sample = $urandom_range(1, 5000);
				else if (pick < 80)
					it.lat_sample = $urandom & 32'h7FFF_FFFF;
				else if (pick < 90)
					it.lat_sample = -$urandom_range(0, 100);
			end
			push_item(it, 1'b0, '0);
		end

		// Wait out every result, then a margin for anything stray.
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ielm_pkg.sv
hdl/ielm_stream_if.sv
hdl/ielm_divider.sv
hdl/ielm_count_ram.sv
hdl/input_event_latency_monitor_unit.sv
sim/tb_top.sv
